### src/typec_attach_state_tracker_top_defines.svh
// Assertion macros for the attach-state tracker.
`ifndef TYPEC_ATTACH_STATE_TRACKER_TOP_DEFINES_SVH
`define TYPEC_ATTACH_STATE_TRACKER_TOP_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define TAST_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define TAST_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/typec_ast_pkg.sv
// Types and constants shared by the attach-state tracker.
`timescale 1ns / 1ps
`default_nettype none

package typec_ast_pkg;

   localparam logic [1:0] CMD_STATUS = 2'd0;
   localparam logic [1:0] CMD_SELECT = 2'd1;
   localparam logic [1:0] CMD_RESET  = 2'd2;

   localparam logic [1:0] ST_NONE = 2'd0;
   localparam logic [1:0] ST_UFP  = 2'd1;
   localparam logic [1:0] ST_DFP  = 2'd2;
   localparam logic [1:0] ST_ACC  = 2'd3;

   localparam logic [1:0] MODE_UFP = 2'd1;
   localparam logic [1:0] MODE_DFP = 2'd2;
   localparam logic [7:0] MODE_MAX = 8'd3;

   localparam logic [2:0] ACC_AUDIO = 3'd4;
   localparam logic [2:0] ACC_DEBUG = 3'd6;

   localparam logic [1:0] PWR_HIGH = 2'd3;
   localparam logic [1:0] PWR_MID  = 2'd1;

   localparam logic [11:0] LIMIT_HIGH_MA = 12'd3000;
   localparam logic [11:0] LIMIT_MID_MA  = 12'd1500;
   localparam logic [11:0] LIMIT_NONE_MA = 12'd0;

   localparam logic [7:0] RESET_KIND_A = 8'd1;
   localparam logic [7:0] RESET_KIND_B = 8'd2;

   localparam logic [1:0] STAT_OK          = 2'd0;
   localparam logic [1:0] STAT_INVALID     = 2'd1;
   localparam logic [1:0] STAT_NOT_ALLOWED = 2'd2;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] attach_byte;
      logic [7:0] detail_byte;
      logic [7:0] requested_mode;
      logic [7:0] reset_kind;
   } req_type;

   typedef struct packed {
      logic [1:0]  reported_state;
      logic [1:0]  tracked_state;
      logic        cable_flip;
      logic [1:0]  sink_power;
      logic [2:0]  accessory_kind;
      logic [1:0]  port_mode;
      logic [11:0] current_limit_ma;
      logic        soft_reset_issued;
      logic        mode_write;
      logic [1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic [1:0] attach_state;
      logic [1:0] mode;
      logic       direction;
      logic [1:0] power;
      logic [2:0] accessory;
   } state_type;

endpackage

`default_nettype wire

### src/typec_ast_step.sv
// Next-state and result logic for one command of the attach-state tracker.
`timescale 1ns / 1ps
`default_nettype none

module typec_ast_step import typec_ast_pkg::*; (
   input  req_type   req,
   input  state_type cur,
   output state_type nxt,
   output rsp_type   rsp
);

   logic [1:0]  ev;
   logic [1:0]  pw;
   logic [2:0]  acc;
   logic [11:0] limit;
   logic        did_reset;
   logic        wrote;
   logic [1:0]  stat;
   state_type   upd;

   assign ev  = req.attach_byte[7:6];
   assign pw  = req.detail_byte[5:4];
   assign acc = req.detail_byte[3:1];

   always_comb begin
      upd       = cur;
      limit     = LIMIT_NONE_MA;
      did_reset = 1'b0;
      wrote     = 1'b0;
      stat      = STAT_OK;
      case (req.command)
         CMD_STATUS: begin
            upd.direction = req.attach_byte[5];
            case (ev)
               ST_NONE: did_reset = 1'b1;
               ST_UFP: begin
                  if (cur.mode != MODE_UFP) begin
                     if (cur.attach_state == ST_NONE) begin
                        upd.attach_state = ST_UFP;
                     end else if (cur.attach_state != ST_UFP) begin
                        did_reset = 1'b1;
                     end
                  end
               end
               ST_DFP: begin
                  if (cur.mode != MODE_DFP) begin
                     if (pw == PWR_HIGH) begin
                        limit = LIMIT_HIGH_MA;
                     end else if (pw == PWR_MID) begin
                        limit = LIMIT_MID_MA;
                     end
                     if (cur.attach_state == ST_NONE) begin
                        upd.attach_state = ST_DFP;
                        upd.power        = pw;
                     end else if (cur.attach_state != ST_DFP) begin
                        did_reset = 1'b1;
                     end
                  end
               end
               default: begin
                  if (cur.attach_state == ST_NONE || cur.attach_state == ST_ACC) begin
                     upd.attach_state = ST_ACC;
                     if (cur.accessory == 3'd0) begin
                        upd.accessory = acc;
                        if (!(acc inside {ACC_AUDIO, ACC_DEBUG})) begin
                           did_reset = 1'b1;
                        end
                     end
                  end else begin
                     did_reset = 1'b1;
                  end
               end
            endcase
         end
         CMD_SELECT: begin
            if (req.requested_mode > MODE_MAX) begin
               stat = STAT_INVALID;
            end else if (cur.attach_state != ST_NONE) begin
               stat = STAT_NOT_ALLOWED;
            end else if (cur.mode != req.requested_mode[1:0]) begin
               upd.mode = req.requested_mode[1:0];
               wrote    = 1'b1;
            end
         end
         CMD_RESET: begin
            if (req.reset_kind inside {RESET_KIND_A, RESET_KIND_B}) begin
               did_reset = 1'b1;
            end else begin
               stat = STAT_INVALID;
            end
         end
         default: stat = STAT_INVALID;
      endcase
   end

   assign nxt = did_reset ? '0 : upd;

   always_comb begin
      rsp                   = '0;
      rsp.reported_state    = (req.command == CMD_STATUS) ? ev : ST_NONE;
      rsp.tracked_state     = nxt.attach_state;
      rsp.cable_flip        = nxt.direction;
      rsp.sink_power        = nxt.power;
      rsp.accessory_kind    = nxt.accessory;
      rsp.port_mode         = nxt.mode;
      rsp.current_limit_ma  = limit;
      rsp.soft_reset_issued = did_reset;
      rsp.mode_write        = wrote;
      rsp.status            = stat;
   end

endmodule

`default_nettype wire

### src/typec_attach_state_tracker_top.sv
// Top level of the USB Type-C attach-state tracker.
// The req_ channel carries one command per transfer: a status event, a port
// mode select or a reset request, with the raw status bytes and arguments.
// The rsp_ channel returns exactly one result per command: the decoded
// attach kind, the tracked state after the command, the current limit and
// flags for soft reset, mode write and status.
// A command sits in an input register, is evaluated against the tracked
// state combinationally, and its result lands in an output register when
// the input register advances; the result is valid on rsp_ from then on
// and holds there until it transfers.
// Throughput is one command per cycle while rsp_stall is low, as the
// tracked state registers update on every advance.
// Reset clears the tracked state (unattached, default mode) and empties
// both registers. While rsp_stall is high the result holds; req_stall
// rises, and the input register keeps its command, only when both are full.
`timescale 1ns / 1ps
`default_nettype none
`include "typec_attach_state_tracker_top_defines.svh"

module typec_attach_state_tracker_top import typec_ast_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic      in_valid_ff;
   logic      in_valid_in;
   req_type   in_data_ff;
   logic      out_valid_ff;
   logic      out_valid_in;
   rsp_type   out_data_ff;
   state_type state_ff;
   state_type state_nxt;
   rsp_type   step_rsp;
   logic      advance;
   logic      req_take;

   typec_ast_step u_step (
      .req (in_data_ff),
      .cur (state_ff),
      .nxt (state_nxt),
      .rsp (step_rsp)
   );

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= step_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   `TAST_ASSERT_NEXT(a_reset_clears_state, advance && step_rsp.soft_reset_issued,
      state_ff == '0, "soft reset left tracked state set")
   `TAST_ASSERT_SAME(a_mode_write_unattached, out_valid_ff && out_data_ff.mode_write,
      out_data_ff.tracked_state == ST_NONE && out_data_ff.status == STAT_OK,
      "mode write while attached or with error status")
   `TAST_ASSERT_SAME(a_limit_only_dfp,
      out_valid_ff && out_data_ff.current_limit_ma != LIMIT_NONE_MA,
      out_data_ff.reported_state == ST_DFP, "current limit on non-DFP event")
   `TAST_ASSERT_NEXT(a_held_command_kept, in_valid_ff && !advance,
      in_valid_ff && $stable(in_data_ff) && $stable(state_ff),
      "held command or state changed without transfer")

endmodule

`default_nettype wire

### sim/typec_attach_state_tracker_top_test.sv
// Self-checking testbench for the Type-C attach-state tracker top level.
`timescale 1ns / 1ps
`default_nettype none

module typec_attach_state_tracker_top_test;
   import typec_ast_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int ITEM_TARGET = 1700;
   localparam int DRAIN_EVERY = 400;
   localparam int IDLE_LIMIT = 2000;
   localparam int TAIL_CYCLES = 10;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   req_type   pending_cmds[$];
   rsp_type   expected_rsps[$];
   state_type port_shadow = '0;
   int        mismatch_count = 0;
   int        items_queued = 0;
   int        rsps_seen = 0;
   int        burst_left = 1;
   int        gap_left = 0;
   int        hold_left = 0;
   int        pattern_left = 0;
   int        pattern_sel = 0;
   int        idle_cycles = 0;

   typec_attach_state_tracker_top uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   always #4 clock = ~clock;

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at result %0d: %s", rsps_seen, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         report_mismatch($sformatf("%s expected %0d got %0d", name, want, got));
      end
   endtask

   // Advance the shadow port state by one command and form its result.
   task automatic predict_port(input req_type cmd, output rsp_type out);
      logic [1:0] kind;
      logic [1:0] pwr;
      logic [2:0] acc;
      logic       clear;
      out = '0;
      clear = 1'b0;
      out.status = STAT_OK;
      case (cmd.command)
         CMD_STATUS: begin
            kind = cmd.attach_byte[7:6];
            pwr = cmd.detail_byte[5:4];
            acc = cmd.detail_byte[3:1];
            out.reported_state = kind;
            port_shadow.direction = cmd.attach_byte[5];
            case (kind)
               ST_NONE: clear = 1'b1;
               ST_UFP: begin
                  if (port_shadow.mode != MODE_UFP) begin
                     if (port_shadow.attach_state == ST_NONE) begin
                        port_shadow.attach_state = ST_UFP;
                     end else if (port_shadow.attach_state != ST_UFP) begin
                        clear = 1'b1;
                     end
                  end
               end
               ST_DFP: begin
                  if (port_shadow.mode != MODE_DFP) begin
                     out.current_limit_ma = (pwr == PWR_HIGH) ? LIMIT_HIGH_MA :
                                            (pwr == PWR_MID)  ? LIMIT_MID_MA : LIMIT_NONE_MA;
                     if (port_shadow.attach_state == ST_NONE) begin
                        port_shadow.attach_state = ST_DFP;
                        port_shadow.power = pwr;
                     end else if (port_shadow.attach_state != ST_DFP) begin
                        clear = 1'b1;
                     end
                  end
               end
               default: begin
                  if (port_shadow.attach_state == ST_NONE || port_shadow.attach_state == ST_ACC) begin
                     port_shadow.attach_state = ST_ACC;
                     if (port_shadow.accessory == 3'd0) begin
                        port_shadow.accessory = acc;
                        if (acc != ACC_AUDIO && acc != ACC_DEBUG) clear = 1'b1;
                     end
                  end else begin
                     clear = 1'b1;
                  end
               end
            endcase
         end
         CMD_SELECT: begin
            if (cmd.requested_mode > MODE_MAX) begin
               out.status = STAT_INVALID;
            end else if (port_shadow.attach_state != ST_NONE) begin
               out.status = STAT_NOT_ALLOWED;
            end else if (port_shadow.mode != cmd.requested_mode[1:0]) begin
               port_shadow.mode = cmd.requested_mode[1:0];
               out.mode_write = 1'b1;
            end
         end
         CMD_RESET: begin
            if (cmd.reset_kind == RESET_KIND_A || cmd.reset_kind == RESET_KIND_B) clear = 1'b1;
            else out.status = STAT_INVALID;
         end
         default: out.status = STAT_INVALID;
      endcase
      if (clear) port_shadow = '0;
      out.soft_reset_issued = clear;
      out.tracked_state = port_shadow.attach_state;
      out.cable_flip = port_shadow.direction;
      out.sink_power = port_shadow.power;
      out.accessory_kind = port_shadow.accessory;
      out.port_mode = port_shadow.mode;
   endtask

   task automatic push_cmd(input logic [1:0] command, input logic [7:0] abyte,
                           input logic [7:0] dbyte, input logic [7:0] mode,
                           input logic [7:0] kind);
      req_type cmd;
      cmd.command = command;
      cmd.attach_byte = abyte;
      cmd.detail_byte = dbyte;
      cmd.requested_mode = mode;
      cmd.reset_kind = kind;
      pending_cmds.push_back(cmd);
      items_queued++;
   endtask

   task automatic push_noise();
      push_cmd(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   task automatic push_event(input logic [1:0] kind);
      logic [2:0] acc;
      acc = ($urandom_range(0, 3) == 0) ? 3'($urandom) :
            (($urandom_range(0, 1) == 0) ? ACC_AUDIO : ACC_DEBUG);
      push_cmd(CMD_STATUS, {kind, 6'($urandom)}, {2'($urandom), 2'($urandom), acc, 1'($urandom)},
               8'($urandom), 8'($urandom));
   endtask

   // One attach session: optional mode select, events mostly of one kind, then usually a detach or reset.
   task automatic push_session();
      logic [1:0] kind;
      int         n;
      int         pick;
      kind = 2'($urandom_range(1, 3));
      pick = $urandom_range(0, 19);
      if (pick < 8) push_cmd(CMD_SELECT, 8'($urandom), 8'($urandom),
                             8'($urandom_range(0, 3)), 8'($urandom));
      else if (pick == 8) push_cmd(CMD_SELECT, 8'($urandom), 8'($urandom),
                                   8'($urandom), 8'($urandom));
      n = $urandom_range(1, 6);
      repeat (n) begin
         pick = $urandom_range(0, 19);
         if (pick < 15) push_event(kind);
         else if (pick < 17) push_event(2'($urandom_range(1, 3)));
         else if (pick < 19) push_cmd(CMD_SELECT, 8'($urandom), 8'($urandom),
                                      8'($urandom_range(0, 5)), 8'($urandom));
         else push_noise();
      end
      pick = $urandom_range(0, 9);
      if (pick < 7) push_cmd(CMD_STATUS, {ST_NONE, 6'($urandom)}, 8'($urandom),
                             8'($urandom), 8'($urandom));
      else if (pick < 9) push_cmd(CMD_RESET, 8'($urandom), 8'($urandom), 8'($urandom),
                                  ($urandom_range(0, 1) == 0) ? RESET_KIND_A : RESET_KIND_B);
   endtask

   task automatic wait_drained();
      while (pending_cmds.size() != 0 || req_valid || expected_rsps.size() != 0) begin
         @(negedge clock);
      end
   endtask

   initial begin
      int next_drain;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      push_cmd(CMD_RESET, 8'h00, 8'h00, 8'h00, RESET_KIND_A);
      push_cmd(CMD_RESET, 8'h00, 8'h00, 8'h00, RESET_KIND_B);
      push_cmd(CMD_RESET, 8'hFF, 8'hFF, 8'hFF, 8'h00);
      push_cmd(CMD_RESET, 8'h00, 8'h00, 8'h00, 8'hFF);
      push_cmd(CMD_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      push_cmd(CMD_SELECT, 8'h00, 8'h00, 8'hFF, 8'h00);
      push_cmd(CMD_SELECT, 8'h00, 8'h00, MODE_MAX + 8'd1, 8'h00);
      push_cmd(CMD_SELECT, 8'h00, 8'h00, MODE_MAX, 8'h00);
      push_cmd(CMD_SELECT, 8'h00, 8'h00, MODE_MAX, 8'h00);
      push_cmd(CMD_SELECT, 8'h00, 8'h00, 8'h00, 8'h00);
      push_cmd(CMD_STATUS, {ST_UFP, 1'b1, 5'h1F}, 8'hFF, 8'h00, 8'h00);
      push_cmd(CMD_STATUS, {ST_UFP, 1'b0, 5'h00}, 8'h00, 8'h00, 8'h00);
      push_cmd(CMD_SELECT, 8'h00, 8'h00, {6'd0, MODE_UFP}, 8'h00);
      push_cmd(CMD_STATUS, {ST_DFP, 1'b1, 5'h00}, 8'h00, 8'h00, 8'h00);
      push_cmd(CMD_STATUS, {ST_DFP, 1'b0, 5'h00}, {2'b11, PWR_HIGH, 4'hF}, 8'h00, 8'h00);
      push_cmd(CMD_STATUS, {ST_DFP, 1'b1, 5'h00}, {2'b00, PWR_MID, 4'h0}, 8'h00, 8'h00);
      push_cmd(CMD_STATUS, 8'h00, 8'h00, 8'h00, 8'h00);
      push_cmd(CMD_SELECT, 8'h00, 8'h00, {6'd0, MODE_DFP}, 8'h00);
      push_cmd(CMD_STATUS, {ST_DFP, 1'b1, 5'h00}, {2'b00, PWR_HIGH, 4'h0}, 8'h00, 8'h00);
      push_cmd(CMD_SELECT, 8'h00, 8'h00, {6'd0, MODE_UFP}, 8'h00);
      push_cmd(CMD_STATUS, {ST_UFP, 1'b1, 5'h00}, 8'h00, 8'h00, 8'h00);
      push_cmd(CMD_STATUS, 8'h3F, 8'hFF, 8'h00, 8'h00);
      push_cmd(CMD_STATUS, {ST_ACC, 1'b0, 5'h00}, {4'h0, ACC_AUDIO, 1'b1}, 8'h00, 8'h00);
      push_cmd(CMD_STATUS, {ST_ACC, 1'b1, 5'h00}, {4'h0, 3'd2, 1'b0}, 8'h00, 8'h00);
      push_cmd(CMD_STATUS, {ST_UFP, 1'b0, 5'h00}, 8'h00, 8'h00, 8'h00);
      push_cmd(CMD_STATUS, {ST_ACC, 1'b0, 5'h00}, {4'h0, 3'd2, 1'b0}, 8'h00, 8'h00);
      push_cmd(CMD_STATUS, {ST_ACC, 1'b1, 5'h00}, {4'h0, ACC_DEBUG, 1'b0}, 8'h00, 8'h00);
      push_cmd(CMD_STATUS, {ST_DFP, 1'b0, 5'h00}, 8'h00, 8'h00, 8'h00);
      push_cmd(CMD_STATUS, 8'hFF, 8'hFF, 8'h00, 8'h00);
      wait_drained();

      next_drain = items_queued + DRAIN_EVERY;
      while (items_queued < ITEM_TARGET) begin
         if ($urandom_range(0, 6) == 0) push_noise();
         else push_session();
         if (items_queued >= next_drain) begin
            wait_drained();
            next_drain = items_queued + DRAIN_EVERY;
         end
      end
      wait_drained();
      repeat (TAIL_CYCLES) @(negedge clock);

      if (mismatch_count == 0 && expected_rsps.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Offer commands in bursts with random gaps; record the prediction on each transfer.
   always @(posedge clock) begin : drive
      rsp_type predicted;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_port(req_data, predicted);
            expected_rsps.push_back(predicted);
         end
         if (req_valid && req_stall) begin
            req_valid <= 1'b1;
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_cmds.size() != 0) begin
            req_data <= pending_cmds.pop_front();
            req_valid <= 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Check each result transfer and drive the stall pattern.
   always @(posedge clock) begin : observe
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("result transfer with nothing expected");
            end else begin
               want = expected_rsps.pop_front();
               check_field("reported_state", want.reported_state, rsp_data.reported_state);
               check_field("tracked_state", want.tracked_state, rsp_data.tracked_state);
               check_field("cable_flip", want.cable_flip, rsp_data.cable_flip);
               check_field("sink_power", want.sink_power, rsp_data.sink_power);
               check_field("accessory_kind", want.accessory_kind, rsp_data.accessory_kind);
               check_field("port_mode", want.port_mode, rsp_data.port_mode);
               check_field("current_limit_ma", want.current_limit_ma, rsp_data.current_limit_ma);
               check_field("soft_reset_issued", want.soft_reset_issued,
                           rsp_data.soft_reset_issued);
               check_field("mode_write", want.mode_write, rsp_data.mode_write);
               check_field("status", want.status, rsp_data.status);
            end
            rsps_seen++;
            if (rsps_seen == 500 || rsps_seen == 1300) hold_left = 120;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (pattern_left <= 0) begin
               pattern_sel = $urandom_range(0, 3);
               pattern_left = $urandom_range(20, 80);
            end
            pattern_left--;
            case (pattern_sel)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= ~rsp_stall;
            endcase
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

endmodule

`default_nettype wire

### typec_attach_state_tracker_top.f
+incdir+src
src/typec_ast_pkg.sv
src/typec_ast_step.sv
src/typec_attach_state_tracker_top.sv
sim/typec_attach_state_tracker_top_test.sv
